FILE: hw/rtl/mbe_pkg.sv
package mbe_pkg;

  localparam int FRAC_BITS_DEF   = 28;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int COORD_W = 32;
  localparam int LIMIT_W = 16;
  localparam int COUNT_W = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd500;

  typedef struct packed {
    logic signed [COORD_W-1:0] im;
    logic signed [COORD_W-1:0] re;
  } point_t;

  typedef logic signed [2*COORD_W-1:0] wide_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input wide_t v);
    logic signed [COORD_W-1:0] res;
    if ((&v[2*COORD_W-1:COORD_W-1]) || !(|v[2*COORD_W-1:COORD_W-1])) begin
      res = v[COORD_W-1:0];
    end else if (v[2*COORD_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/mbe_front.sv
module mbe_front
  import mbe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*COORD_W-1:0] in_tdata,
  output logic                 q_valid,
  input  logic                 q_ready,
  output point_t               q_point
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  point_t             entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               push, pop;

  assign in_tready = (fill_r != CNT_W'(DEPTH));
  assign q_valid   = (fill_r != '0);
  assign q_point   = entry_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= point_t'(in_tdata);
    end
  end

endmodule

FILE: hw/rtl/mbe_iter.sv
module mbe_iter
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               q_valid,
  output logic               q_ready,
  input  point_t             q_point,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata
);

  localparam logic [2*COORD_W-1:0] FOUR =
    (2 * FRAC_BITS > 61) ? '1 : (64'd4 << (2 * FRAC_BITS));

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_EVAL = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [COUNT_BITS-1:0]     limit_r;
  logic [COUNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic signed [COORD_W-1:0] z_re_r, z_re_nxt, z_im_r, z_im_nxt;
  logic signed [COORD_W-1:0] c_re_r, c_im_r;
  wide_t                     rr_r, ii_r, ri_r;
  logic                      esc_r, esc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_esc_r;
  logic [2*COORD_W-1:0]      mag;
  wide_t                     new_re, new_im;
  logic                      stop, slot_free;

  assign mag       = $unsigned(rr_r) + $unsigned(ii_r);
  assign new_re    = ((rr_r - ii_r) >>> FRAC_BITS) + wide_t'(c_re_r);
  assign new_im    = (ri_r >>> (FRAC_BITS - 1)) + wide_t'(c_im_r);
  assign stop      = (mag > FOUR) || (cnt_r >= limit_r);
  assign slot_free = !out_valid_r || out_tready;

  assign q_ready    = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_esc_r, out_count_r};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    z_re_nxt      = z_re_r;
    z_im_nxt      = z_im_r;
    esc_nxt       = esc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cnt_nxt   = '0;
          z_re_nxt  = '0;
          z_im_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stop) begin
          esc_nxt   = (cnt_r < limit_r);
          state_nxt = S_EMIT;
        end else begin
          z_re_nxt  = sat_coord(new_re);
          z_im_nxt  = sat_coord(new_im);
          cnt_nxt   = cnt_r + COUNT_BITS'(1);
          state_nxt = S_MUL;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= COUNT_BITS'(LIMIT_RESET);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= COUNT_BITS'(cfg_wr_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    z_re_r <= z_re_nxt;
    z_im_r <= z_im_nxt;
    esc_r  <= esc_nxt;
    rr_r   <= wide_t'(z_re_r) * wide_t'(z_re_r);
    ii_r   <= wide_t'(z_im_r) * wide_t'(z_im_r);
    ri_r   <= wide_t'(z_re_r) * wide_t'(z_im_r);
    if (state_r == S_IDLE && q_valid) begin
      c_re_r <= q_point.re;
      c_im_r <= q_point.im;
    end
    if (state_r == S_EMIT && slot_free) begin
      out_count_r <= COUNT_W'(cnt_r);
      out_esc_r   <= esc_r;
    end
  end

endmodule

FILE: hw/rtl/mandelbrot_escape_time.sv
// Channel  Direction  Beat contents
// in_      slave      tdata: c_real [31:0], c_imag [63:32]
// out_     master     tdata: iteration_count [15:0], escaped [16], zero [23:17]
// cfg_     write      wr_data: iteration_limit [15:0]
//
// Each iteration registers the products of the three multipliers in S_MUL and
// then checks for escape and updates z in S_EVAL.
// Reset is synchronous and active low, and sets the limit to 500.
// A small input queue keeps taking beats while a point iterates, and a result
// held by a stalled output waits in the engine without losing the next point.
module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // c_real [31:0], c_imag [63:32]
  input  logic [2*COORD_W-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // iteration_count [15:0], escaped [16], zero [23:17]
  output logic [23:0]          out_tdata,
  input  logic                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]   cfg_wr_data
);

  logic   q_valid;
  logic   q_ready;
  point_t q_point;

  mbe_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_point  (q_point)
  );

  mbe_iter #(
    .FRAC_BITS (FRAC_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_iter (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_point    (q_point),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mbe_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint unsigned MAG_BOUND = (2 * FRAC > 61) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                          : (64'd4 << (2 * FRAC));
  localparam int WATCHDOG_CYCLES = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [COORD_W-1:0] ONE = 32'sh1000_0000;
  localparam logic signed [COORD_W-1:0] TWO = 32'sh2000_0000;
  localparam logic signed [COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               escaped;
  } escape_t;

  typedef struct packed {
    bit      known;
    escape_t res;
  } hint_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]        lim;
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
    bit                        known;
    logic [COUNT_W-1:0]        count;
    logic                      escaped;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [2*COORD_W-1:0] in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 cfg_wr_en;
  logic [LIMIT_W-1:0]   cfg_wr_data;

  logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;
  hint_t              hint_q[$];
  escape_t            pending[$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 hold_asks = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  int                 stall_left = 0;
  bit                 quiet = 1'b0;
  bit                 calm = 1'b0;

  mandelbrot_escape_time dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fit_coord(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic escape_t predict_escape(input point_t c, input logic [LIMIT_W-1:0] lim);
    longint zr, zi, rr, ii;
    longint unsigned mag;
    int unsigned steps;
    escape_t r;
    zr = 0;
    zi = 0;
    steps = 0;
    forever begin
      rr = zr * zr;
      ii = zi * zi;
      mag = rr + ii;
      if (mag > MAG_BOUND || steps >= lim) begin
        break;
      end
      rr = ((rr - ii) >>> FRAC) + longint'(c.re);
      ii = ((zr * zi) >>> (FRAC - 1)) + longint'(c.im);
      zr = fit_coord(rr);
      zi = fit_coord(ii);
      steps++;
    end
    r.count = steps[COUNT_W-1:0];
    r.escaped = (steps < lim);
    return r;
  endfunction

  function automatic point_t pick_point(input bit wild);
    point_t p;
    if (wild || $urandom_range(0, 3) == 0) begin
      p.re = $urandom;
      p.im = $urandom;
    end else begin
      p.re = int'($urandom_range(0, 671088640)) - 536870912;
      p.im = int'($urandom_range(0, 671088640)) - 335544320;
    end
    return p;
  endfunction

  task automatic flag_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch in %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $time);
    errors++;
  endtask

  task automatic send_point(input point_t p, input hint_t h, input bit eager);
    int gap;
    gap = 0;
    if (!eager && !quiet && !calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hint_q.push_back(h);
    in_tdata <= p;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending.size() != 0 || hint_q.size() != 0);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] lim);
    if (lim != cur_limit) begin
      wait_drained();
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= lim;
      @(posedge clk);
      cur_limit = lim;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
    end
  endtask

  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hint_t   h;
    escape_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        h = hint_q.pop_front();
        pending.push_back(h.known ? h.res : predict_escape(point_t'(in_tdata), cur_limit));
      end
      if (out_tvalid && out_tready) begin
        if (pending.size() == 0) begin
          flag_mismatch("unexpected result beat", -1, out_tdata[COUNT_W-1:0]);
        end else begin
          want = pending.pop_front();
          if (out_tdata[COUNT_W-1:0] !== want.count) begin
            flag_mismatch("iteration_count", want.count, out_tdata[COUNT_W-1:0]);
          end
          if (out_tdata[16] !== want.escaped) begin
            flag_mismatch("escaped", want.escaped, out_tdata[16]);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  stim_row_t directed[] = '{
    '{16'd500,   0,     0,     1'b1, 16'd500,   1'b0},
    '{16'd500,   CMAX,  CMAX,  1'b1, 16'd1,     1'b1},
    '{16'd500,   CMIN,  CMIN,  1'b1, 16'd1,     1'b1},
    '{16'd500,   CMAX,  CMIN,  1'b1, 16'd1,     1'b1},
    '{16'd500,   -TWO,  0,     1'b1, 16'd500,   1'b0},
    '{16'd500,   0,     TWO,   1'b1, 16'd2,     1'b1},
    '{16'd500,   0,     -TWO,  1'b1, 16'd2,     1'b1},
    '{16'd500,   TWO,   0,     1'b1, 16'd2,     1'b1},
    '{16'd500,   ONE,   0,     1'b1, 16'd3,     1'b1},
    '{16'd500,   -32'sh0C00_0001, 32'sh0000_1235, 1'b0, 16'd0, 1'b0},
    '{16'd500,   32'sh0400_0001,  0,              1'b0, 16'd0, 1'b0},
    '{16'd500,   -32'sh0123_4567, -32'sh0765_4321, 1'b0, 16'd0, 1'b0},
    '{16'd500,   32'sh0000_0001,  -32'sh0000_0001, 1'b0, 16'd0, 1'b0},
    '{16'd3,     ONE,   0,     1'b1, 16'd3,     1'b0},
    '{16'd4,     ONE,   0,     1'b1, 16'd3,     1'b1},
    '{16'd1,     0,     0,     1'b1, 16'd1,     1'b0},
    '{16'd1,     CMAX,  CMAX,  1'b1, 16'd1,     1'b0},
    '{16'd65535, -TWO,  0,     1'b1, 16'd65535, 1'b0},
    '{16'd65535, CMAX,  0,     1'b1, 16'd1,     1'b1},
    '{16'd65535, -32'sh1C00_0000, 32'sh0000_0100, 1'b0, 16'd0, 1'b0},
    '{16'd500,   32'sh3FFF_FFFF,  -32'sh4000_0000, 1'b1, 16'd1, 1'b1}
  };

  initial begin
    point_t             p;
    hint_t              h;
    logic [LIMIT_W-1:0] lim;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[k]) begin
      set_limit(directed[k].lim);
      p.re = directed[k].re;
      p.im = directed[k].im;
      h.known = directed[k].known;
      h.res.count = directed[k].count;
      h.res.escaped = directed[k].escaped;
      send_point(p, h, 1'b0);
    end

    h = '0;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        lim = 16'd2;
      end else if (phase == 5) begin
        lim = 16'd500;
      end else begin
        lim = $urandom_range(5, 80);
      end
      wait_drained();
      set_limit(lim);
      calm = (phase == 2);
      quiet = (phase == 7);
      for (int i = 0; i < 150; i++) begin
        if (phase == 3 && i == 0) begin
          hold_asks++;
        end
        if (phase == 4 && i == 75) begin
          wait_drained();
        end
        p = pick_point(phase == 3 && i < 30);
        send_point(p, h, phase == 3 && i < 30);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_front.sv
hw/rtl/mbe_iter.sv
hw/rtl/mandelbrot_escape_time.sv
tb/sv/testbench.sv
